[src/ssbp_pkg.sv]
// Shared types, constants and word helpers for the subset-sum partition block.
package ssbp_pkg;

	localparam int SUM_W = 17;
	localparam int WORD_W = 64;
	localparam int WIDX_W = 6;
	localparam int CNT_W = WIDX_W + 1;
	localparam int DIFF_W = SUM_W + 3;
	localparam int TOP_MAX = 65536;
	localparam int TARGET_CAPACITY_DEF = 65536;

	typedef struct packed {
		logic [SUM_W-1:0] element_value;
		logic             last_element;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] best_larger_sum;
		logic             perfect_found;
	} result_t;

	// Ones in the low n bits of a word, n in 0..64.
	function automatic logic [WORD_W-1:0] therm(input logic [CNT_W-1:0] n);
		logic [WORD_W-1:0] m;
		if (n[CNT_W-1]) begin
			m = '1;
		end else begin
			m = ({{(WORD_W-1){1'b0}}, 1'b1} << n[WIDX_W-1:0]) - {{(WORD_W-1){1'b0}}, 1'b1};
		end
		return m;
	endfunction

	// Clamp a two's complement difference into a bit count 0..64.
	function automatic logic [CNT_W-1:0] sat_cnt(input logic [DIFF_W-1:0] x);
		logic [CNT_W-1:0] n;
		if (x[DIFF_W-1]) begin
			n = '0;
		end else if (x > DIFF_W'(WORD_W)) begin
			n = CNT_W'(WORD_W);
		end else begin
			n = x[CNT_W-1:0];
		end
		return n;
	endfunction

	// Position of the highest set bit.
	function automatic logic [WIDX_W-1:0] msb_idx(input logic [WORD_W-1:0] x);
		logic [WIDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (x[i]) begin
				idx = WIDX_W'(i);
			end
		end
		return idx;
	endfunction

	// Position of the lowest set bit.
	function automatic logic [WIDX_W-1:0] lsb_idx(input logic [WORD_W-1:0] x);
		logic [WIDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (x[i]) begin
				idx = WIDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

[src/ssbp_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
module ssbp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then read both ports with old data on the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[src/subset_sum_bitset_partition.sv]
// Two-way partition by a subset-sum bitset held in a word-wide RAM.
// Per item it sweeps J = max(1, ceil(min(target, TARGET_CAPACITY)/64)) source words, one RAM
// word at a time in a descending pass, then drains, scores and reaches the output state.
// A new item is taken only once the block is idle again; after a perfect hit, an item skips
// the sweep and scoring. A last item raises done from the output state, then the block
// clears the RAM. Reset runs the same clear pass with busy high; config stays open.
module subset_sum_bitset_partition #(
	parameter int TARGET_CAPACITY = ssbp_pkg::TARGET_CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ssbp_pkg::SUM_W-1:0] cfg_data,
	input  logic                       start,
	input  ssbp_pkg::item_t            item,
	output logic                       busy,
	output logic                       done,
	output ssbp_pkg::result_t          result
);
	import ssbp_pkg::*;

	localparam int WORDS = (TARGET_CAPACITY + WORD_W - 1) / WORD_W;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CAP_LIM = (TARGET_CAPACITY < TOP_MAX) ? TARGET_CAPACITY : TOP_MAX;
	localparam int JW = SUM_W - WIDX_W;
	localparam int DW = JW + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SWEEP, ST_DRAIN, ST_FIN1, ST_FIN2, ST_FIN3, ST_EMIT, ST_CLEAR
	} state_t;

	state_t            state_q;
	logic [SUM_W-1:0]  total_q;
	logic [SUM_W-1:0]  elem_q;
	logic              last_q;
	logic              started_q;
	logic              perfect_q;
	logic [SUM_W-1:0]  best_q;
	logic [JW-1:0]     d_q;
	logic [ADDR_W-1:0] clr_q;
	logic [WORD_W-1:0] lo_prev_q;
	logic              bel_found_q;
	logic [SUM_W-1:0]  bel_v_q;
	logic              abv_found_q;
	logic [SUM_W-1:0]  abv_v_q;
	logic [SUM_W:0]    nv_b_q;
	logic [SUM_W:0]    nv_a_q;
	logic [SUM_W-1:0]  comp_q;
	logic              hit_q;
	logic              done_q;
	result_t           result_q;

	// Stage 1 registers: one RAM word in flight
	logic              sweep_s1;
	logic              src_en_s1;
	logic [JW-1:0]     j_s1;
	logic [CNT_W-1:0]  src_n_s1;
	logic [CNT_W-1:0]  th_n_s1;
	logic [CNT_W-1:0]  dst_n_s1;
	logic              dst_ok_s1;
	logic [ADDR_W-1:0] dst_addr_s1;

	logic [SUM_W:0]      sum_inc;
	logic [SUM_W-1:0]    target;
	logic [SUM_W-1:0]    top;
	logic [SUM_W-1:0]    top_dec;
	logic [JW-1:0]       first_d;
	logic [JW-1:0]       k;
	logic [WIDX_W-1:0]   r;
	logic [JW-1:0]       j_s0;
	logic [DW-1:0]       dest_s0;
	logic [DIFF_W-1:0]   src_diff;
	logic [DIFF_W-1:0]   th_diff;
	logic [DIFF_W-1:0]   dst_diff;
	logic                rd_src_en;

	logic [WORD_W-1:0]   rd_a;
	logic [WORD_W-1:0]   rd_b;
	logic [WORD_W-1:0]   src_raw;
	logic [WORD_W-1:0]   src_w;
	logic [WORD_W-1:0]   low_mask;
	logic [WORD_W-1:0]   below;
	logic [WORD_W-1:0]   above;
	logic [2*WORD_W-1:0] shifted;
	logic [WORD_W-1:0]   new_bits;
	logic [WORD_W-1:0]   wr_word;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr_a;
	logic [ADDR_W-1:0]   mem_raddr_b;

	logic [SUM_W-1:0]    best_a;
	logic [SUM_W-1:0]    best_b;

	// Derive target and the swept range from the configured total
	assign sum_inc = {1'b0, total_q} + {{SUM_W{1'b0}}, 1'b1};
	assign target  = sum_inc[SUM_W:1];
	assign top     = (target < SUM_W'(CAP_LIM)) ? target : SUM_W'(CAP_LIM);
	assign top_dec = top - {{(SUM_W-1){1'b0}}, 1'b1};
	assign first_d = (top == '0) ? JW'(1) : top_dec[SUM_W-1:WIDX_W] + JW'(1);
	assign k       = elem_q[SUM_W-1:WIDX_W];
	assign r       = elem_q[WIDX_W-1:0];

	// Issue stage: source word d-1 and destination word d+k
	assign rd_src_en = (state_q == ST_SWEEP) && (d_q != '0);
	assign j_s0      = d_q - JW'(1);
	assign dest_s0   = {1'b0, d_q} + {1'b0, k};
	assign src_diff  = {{(DIFF_W-SUM_W){1'b0}}, top}
		- {{(DIFF_W-SUM_W){1'b0}}, j_s0, {WIDX_W{1'b0}}};
	assign th_diff   = {{(DIFF_W-SUM_W){1'b0}}, target}
		- {{(DIFF_W-SUM_W){1'b0}}, elem_q}
		- {{(DIFF_W-SUM_W){1'b0}}, j_s0, {WIDX_W{1'b0}}};
	assign dst_diff  = {{(DIFF_W-SUM_W){1'b0}}, top}
		- {{(DIFF_W-DW-WIDX_W){1'b0}}, dest_s0, {WIDX_W{1'b0}}};
	assign mem_raddr_a = ADDR_W'(j_s0);
	assign mem_raddr_b = ADDR_W'(dest_s0);

	// Advance the word pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_s1 <= 1'b0;
		end else begin
			sweep_s1 <= (state_q == ST_SWEEP);
		end
	end

	always_ff @(posedge clk) begin
		src_en_s1   <= rd_src_en;
		j_s1        <= j_s0;
		src_n_s1    <= sat_cnt(src_diff);
		th_n_s1     <= sat_cnt(th_diff);
		dst_n_s1    <= sat_cnt(dst_diff);
		dst_ok_s1   <= (32'(dest_s0) < 32'(WORDS));
		dst_addr_s1 <= mem_raddr_b;
	end

	// Mask live sums, add the element alone at sum zero, split by target
	always_comb begin
		src_raw  = src_en_s1 ? rd_a : '0;
		src_w    = (src_raw & therm(src_n_s1))
			| {{(WORD_W-1){1'b0}}, (src_en_s1 && (j_s1 == '0))};
		low_mask = therm(th_n_s1);
		below    = src_w & low_mask;
		above    = src_w & ~low_mask;
		shifted  = {{WORD_W{1'b0}}, src_w} << r;
		new_bits = shifted[2*WORD_W-1:WORD_W] | lo_prev_q;
		wr_word  = rd_b | (new_bits & therm(dst_n_s1));
	end

	// Share the write port between sweep write-back and clearing
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = sweep_s1 && dst_ok_s1;
			mem_waddr = dst_addr_s1;
			mem_wdata = wr_word;
		end
	end

	ssbp_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.rdata_a (rd_a),
		.raddr_b (mem_raddr_b),
		.rdata_b (rd_b)
	);

	// Fold both candidates into the best larger-part sum
	always_comb begin
		best_a = (bel_found_q && (comp_q < best_q)) ? comp_q : best_q;
		best_b = (abv_found_q && (nv_a_q < {1'b0, best_a})) ? nv_a_q[SUM_W-1:0] : best_a;
	end

	// Hold the configured total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= cfg_data;
		end
	end

	// Sequence one item: sweep, score, emit, and clear after a last item; after a perfect hit, emit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			elem_q      <= '0;
			last_q      <= 1'b0;
			started_q   <= 1'b0;
			perfect_q   <= 1'b0;
			best_q      <= '0;
			d_q         <= '0;
			clr_q       <= '0;
			lo_prev_q   <= '0;
			bel_found_q <= 1'b0;
			bel_v_q     <= '0;
			abv_found_q <= 1'b0;
			abv_v_q     <= '0;
			nv_b_q      <= '0;
			nv_a_q      <= '0;
			comp_q      <= '0;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q <= 1'b0;

			// Track the highest sum below target and the lowest at or above it
			if (sweep_s1) begin
				lo_prev_q <= shifted[WORD_W-1:0];
				if ((|below) && !bel_found_q) begin
					bel_found_q <= 1'b1;
					bel_v_q     <= {j_s1, msb_idx(below)};
				end
				if (|above) begin
					abv_found_q <= 1'b1;
					abv_v_q     <= {j_s1, lsb_idx(above)};
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						elem_q      <= item.element_value;
						last_q      <= item.last_element;
						bel_found_q <= 1'b0;
						abv_found_q <= 1'b0;
						lo_prev_q   <= '0;
						d_q         <= first_d;
						if (!started_q) begin
							started_q <= 1'b1;
							best_q    <= total_q;
						end
						if (started_q && perfect_q) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (d_q == '0) begin
						state_q <= ST_DRAIN;
					end else begin
						d_q <= d_q - JW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN1;
				end
				ST_FIN1: begin
					nv_b_q  <= {1'b0, bel_v_q} + {1'b0, elem_q};
					nv_a_q  <= {1'b0, abv_v_q} + {1'b0, elem_q};
					state_q <= ST_FIN2;
				end
				ST_FIN2: begin
					comp_q  <= total_q - nv_b_q[SUM_W-1:0];
					hit_q   <= abv_found_q && (nv_a_q == {1'b0, target});
					state_q <= ST_FIN3;
				end
				ST_FIN3: begin
					// A perfect hit pins the best sum to the target
					best_q    <= hit_q ? target : best_b;
					perfect_q <= perfect_q | hit_q;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (last_q) begin
						done_q                   <= 1'b1;
						result_q.best_larger_sum <= best_q;
						result_q.perfect_found   <= perfect_q;
						started_q                <= 1'b0;
						perfect_q                <= 1'b0;
						clr_q                    <= '0;
						state_q                  <= ST_CLEAR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					if (clr_q == ADDR_W'(WORDS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + ADDR_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// An accepted item makes the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// A result leaves only from the output state
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_EMIT))
		else $error("result strobe outside output state");

	// Write-back never hits the word being read as a source
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && rd_src_en |-> mem_waddr != mem_raddr_a)
		else $error("write-back collides with source read");

	// Clearing never overlaps a sweep write-back
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !sweep_s1)
		else $error("sweep write-back during clear pass");

endmodule

[tb/tb_subset_sum_bitset_partition.sv]
// Self-checking testbench for the subset-sum bitset partition block: directed, then random.
module tb_subset_sum_bitset_partition;
	import ssbp_pkg::*;

	localparam int CAP = TARGET_CAPACITY_DEF;
	localparam int MAX_VAL = (1 << SUM_W) - 1;
	// Covers the longest item at full capacity plus margin
	localparam int SETTLE_CYCLES = 1100;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int PHASE_ITEMS = 44;
	localparam int NUM_PHASES = 12;
	localparam int NUM_ROWS = 21;
	localparam int MAX_REPORTS = 20;

	typedef struct {
		int unsigned total;
		int unsigned elem;
		bit          last;
		bit          typed;
		int unsigned exp_best;
		bit          exp_perfect;
	} dir_row_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [SUM_W-1:0] cfg_data = '0;
	logic             start = 1'b0;
	item_t            item = '0;
	logic             busy;
	logic             done;
	result_t          result;

	subset_sum_bitset_partition dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	// Partition state mirrored from the block
	bit          reach_map [0:CAP-1];
	int unsigned reach_top;
	int unsigned best_larger;
	bit          perfect_hit;
	bit          problem_open;
	int unsigned total_cfg;

	result_t     expected_partitions [$];
	int unsigned mismatches;
	int unsigned cycles;
	int unsigned burst_left;
	dir_row_t    dir_rows [0:NUM_ROWS-1];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Score one candidate sum against the target
	function automatic void score_sum(input int unsigned nv, input int unsigned tgt);
		if (nv < tgt) begin
			if (nv < CAP) begin
				reach_map[nv] = 1'b1;
				if (nv + 1 > reach_top) begin
					reach_top = nv + 1;
				end
			end
			if (total_cfg - nv < best_larger) begin
				best_larger = total_cfg - nv;
			end
		end else if (nv == tgt) begin
			perfect_hit = 1'b1;
			best_larger = tgt;
		end else if (nv < best_larger) begin
			best_larger = nv;
		end
	endfunction

	// Add one element to the reachable sums; close the problem on a last item
	task automatic predict_partition(input item_t it, output bit has_res, output result_t res);
		int unsigned s;
		int unsigned tgt;
		int unsigned top;
		int unsigned v;
		s = it.element_value;
		tgt = (total_cfg + 1) / 2;
		has_res = 1'b0;
		res = '0;
		if (!problem_open) begin
			problem_open = 1'b1;
			best_larger = total_cfg;
			perfect_hit = 1'b0;
		end
		if (!perfect_hit) begin
			top = (tgt < CAP) ? tgt : CAP;
			// bits at or above reach_top are clear, so skip them
			if (top > reach_top) begin
				top = reach_top;
			end
			v = top;
			while (v > 0 && !perfect_hit) begin
				v--;
				if (reach_map[v]) begin
					score_sum(v + s, tgt);
				end
			end
			if (!perfect_hit) begin
				score_sum(s, tgt);
			end
		end
		if (it.last_element) begin
			has_res = 1'b1;
			res.best_larger_sum = SUM_W'(best_larger);
			res.perfect_found = perfect_hit;
			for (int i = 0; i < reach_top; i++) begin
				reach_map[i] = 1'b0;
			end
			reach_top = 0;
			perfect_hit = 1'b0;
			problem_open = 1'b0;
		end
	endtask

	// Check each strobed result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_partitions.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t unexpected result: expected none, actual best %0d perfect %0d",
						$time, result.best_larger_sum, result.perfect_found);
				end
			end else begin
				if (result.best_larger_sum !== expected_partitions[0].best_larger_sum) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t best_larger_sum: expected %0d, actual %0d", $time,
							expected_partitions[0].best_larger_sum, result.best_larger_sum);
					end
				end
				if (result.perfect_found !== expected_partitions[0].perfect_found) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t perfect_found: expected %0d, actual %0d", $time,
							expected_partitions[0].perfect_found, result.perfect_found);
					end
				end
				void'(expected_partitions.pop_front());
			end
		end
	end

	// Drive one item in bursts and gaps; predict at the accepting edge
	task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
		int unsigned gap;
		bit has_res;
		result_t res;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(20, 60);
				gap = $urandom_range(0, 2);
			end else begin
				burst_left = $urandom_range(1, 10);
				gap = $urandom_range(1, 12);
			end
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do begin
			@(posedge clk);
		end while (busy);
		burst_left--;
		predict_partition(it, has_res, res);
		if (has_res) begin
			expected_partitions.push_back(typed ? typed_res : res);
		end
	endtask

	// Hold off until every result is in and the block is idle
	task automatic wait_idle();
		start <= 1'b0;
		while (expected_partitions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_total(input int unsigned value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= SUM_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		total_cfg = value;
	endtask

	// Random problems for one total: mostly exact splits, some loose and noisy ones
	task automatic run_phase(input int unsigned total);
		int unsigned sent;
		int unsigned k;
		int unsigned mode;
		int unsigned rem;
		int unsigned part;
		bit paused;
		item_t it;
		result_t none;
		sent = 0;
		paused = 1'b0;
		none = '0;
		write_total(total);
		while (sent < PHASE_ITEMS) begin
			k = $urandom_range(1, 8);
			mode = $urandom_range(0, 9);
			rem = total;
			for (int i = 0; i < k; i++) begin
				if (mode <= 6) begin
					if (i == k - 1) begin
						part = rem;
					end else begin
						part = $urandom_range(0, (2 * rem) / (k - i));
						if (part > rem) begin
							part = rem;
						end
					end
					rem -= part;
				end else if (mode <= 8) begin
					part = $urandom_range(0, (total > 0) ? total : 1);
				end else begin
					part = $urandom_range(0, MAX_VAL);
				end
				it.element_value = SUM_W'(part);
				it.last_element = (i == k - 1);
				send_item(it, 1'b0, none);
				sent++;
				// drain everything once mid-phase
				if (!paused && sent >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					start <= 1'b0;
					do begin
						@(posedge clk);
					end while (expected_partitions.size() != 0);
				end
			end
		end
	endtask

	initial begin
		item_t it;
		result_t exp_res;
		int cur_total;

		reach_top = 0;
		best_larger = 0;
		perfect_hit = 1'b0;
		problem_open = 1'b0;
		total_cfg = 0;
		mismatches = 0;
		cycles = 0;
		burst_left = 0;
		cur_total = -1;
		for (int i = 0; i < CAP; i++) begin
			reach_map[i] = 1'b0;
		end

		// total, element, last, typed, expected best, expected perfect
		dir_rows = '{
			'{0,      0,      1'b1, 1'b1, 0,      1'b1},
			'{0,      131071, 1'b1, 1'b1, 0,      1'b0},
			'{10,     3,      1'b0, 1'b0, 0,      1'b0},
			'{10,     2,      1'b1, 1'b1, 5,      1'b1},
			'{10,     4,      1'b0, 1'b0, 0,      1'b0},
			'{10,     3,      1'b0, 1'b0, 0,      1'b0},
			'{10,     9,      1'b1, 1'b0, 0,      1'b0},
			'{10,     5,      1'b0, 1'b0, 0,      1'b0},
			'{10,     7,      1'b0, 1'b0, 0,      1'b0},
			'{10,     1,      1'b1, 1'b1, 5,      1'b1},
			'{131071, 65535,  1'b1, 1'b1, 65536,  1'b0},
			'{131071, 65536,  1'b1, 1'b1, 65536,  1'b1},
			'{131071, 131071, 1'b1, 1'b1, 131071, 1'b0},
			'{131071, 0,      1'b1, 1'b1, 131071, 1'b0},
			'{131071, 1,      1'b0, 1'b0, 0,      1'b0},
			'{131071, 65534,  1'b1, 1'b0, 0,      1'b0},
			'{1,      1,      1'b1, 1'b1, 1,      1'b1},
			'{1,      0,      1'b1, 1'b1, 1,      1'b0},
			'{100,    60,     1'b1, 1'b1, 60,     1'b0},
			'{100,    25,     1'b0, 1'b0, 0,      1'b0},
			'{100,    50,     1'b1, 1'b1, 50,     1'b1}
		};

		// Hold reset, then release it
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; change the total only between problems
		for (int r = 0; r < NUM_ROWS; r++) begin
			if (cur_total != int'(dir_rows[r].total)) begin
				write_total(dir_rows[r].total);
				cur_total = dir_rows[r].total;
			end
			it.element_value = SUM_W'(dir_rows[r].elem);
			it.last_element = dir_rows[r].last;
			exp_res.best_larger_sum = SUM_W'(dir_rows[r].exp_best);
			exp_res.perfect_found = dir_rows[r].exp_perfect;
			send_item(it, dir_rows[r].typed, exp_res);
		end

		// Random phases: both total extremes, then a spread of totals
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: run_phase(MAX_VAL);
				1: run_phase(0);
				2: run_phase($urandom_range(0, MAX_VAL));
				3: run_phase(1);
				default: run_phase($urandom_range(2, 4000));
			endcase
		end

		wait_idle();
		if (expected_partitions.size() != 0) begin
			mismatches++;
			$display("%0t %0d expected results never arrived", $time, expected_partitions.size());
		end
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
